[src/nnds_pkg.sv]
`default_nettype none

package nnds_pkg;

   // largest frame edge, and the widths that follow from the field widths
   localparam int MAX_DIM = 4096;
   localparam int DIM_W   = 13;
   localparam int COORD_W = 12;
   localparam int CSR_IDX_W = 2;

   localparam logic [DIM_W-1:0] RST_SOURCE_WIDTH  = 13'd1920;
   localparam logic [DIM_W-1:0] RST_SOURCE_HEIGHT = 13'd1080;
   localparam logic [DIM_W-1:0] RST_TARGET_WIDTH  = 13'd192;
   localparam logic [DIM_W-1:0] RST_TARGET_HEIGHT = 13'd108;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SOURCE_WIDTH  = 2'd0,
      REG_SOURCE_HEIGHT = 2'd1,
      REG_TARGET_WIDTH  = 2'd2,
      REG_TARGET_HEIGHT = 2'd3
   } csr_reg_type;

   // frame geometry with the targets already limited to the source size
   typedef struct packed {
      logic [DIM_W-1:0] src_w;
      logic [DIM_W-1:0] src_h;
      logic [DIM_W-1:0] tgt_w;
      logic [DIM_W-1:0] tgt_h;
   } geometry_type;

   // zero counts as one, anything above the maximum as the maximum
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] value);
      logic [DIM_W-1:0] result;
      result = value;
      if (value == '0) begin
         result = DIM_W'(1);
      end else if (value > DIM_W'(MAX_DIM)) begin
         result = DIM_W'(MAX_DIM);
      end
      return result;
   endfunction

endpackage

`default_nettype wire

[src/nearest_neighbor_downscaler_core.sv]
// channel   | direction | ports                                  | contents
// ----------+-----------+----------------------------------------+---------------------------
// request   | in        | req_tvalid req_tready req_tdata        | one source pixel
// response  | out       | rsp_tvalid rsp_tready rsp_tdata        | pixel, target col and row
//           |           | rsp_tlast                              | last pixel of scaled frame
// control   | in        | csr_valid csr_ready csr_index csr_data | size register write
//
// one source pixel per cycle sustained unless the response stalls or a register write or
// ratio calculation is pending; a selected pixel passes the input register and then the
// result register, a skipped one only the input register; after reset and after every
// register write the two step ratios come from bit-serial dividers, which keep req_tready low
// a register write waits for an empty input register and holds off req_tready
// reset is synchronous and active high; it restores the default frame sizes
// a selected pixel waiting on a stalled response keeps req_tready low
`default_nettype none

module nearest_neighbor_downscaler_core
   import nnds_pkg::*;
   #(
      parameter int FRAC_BITS       = 16,
      parameter int BYTES_PER_PIXEL = 4
   )
   (
      input  wire logic                          clock,
      input  wire logic                          reset,
      // request channel
      input  wire logic                          req_tvalid,
      output logic                               req_tready,
      input  wire logic [8*BYTES_PER_PIXEL-1:0]  req_tdata,   // pixel_in
      // response channel
      output logic                               rsp_tvalid,
      input  wire logic                          rsp_tready,
      output logic [((8*BYTES_PER_PIXEL+2*COORD_W+7)/8)*8-1:0] rsp_tdata,
                                          // pixel_out, dest_col, dest_row
      output logic                               rsp_tlast,   // frame_last
      // control channel
      input  wire logic                          csr_valid,
      output logic                               csr_ready,
      input  wire logic [CSR_IDX_W-1:0]          csr_index,
      input  wire logic [DIM_W-1:0]              csr_data
   );

   localparam int PIX_W      = 8 * BYTES_PER_PIXEL;
   localparam int RSP_DATA_W = ((PIX_W + 2 * COORD_W + 7) / 8) * 8;
   localparam int POS_W      = DIM_W + FRAC_BITS;

   geometry_type       geometry;
   logic [POS_W-1:0]   col_ratio, row_ratio;
   logic               ratio_busy;
   logic               csr_write;

   // input register
   logic               in_valid_ff, in_valid_in;
   logic [PIX_W-1:0]   pixel_ff, pixel_in;

   // result register
   logic               out_valid_ff, out_valid_in;
   logic [PIX_W-1:0]   out_pixel_ff, out_pixel_in;
   logic [COORD_W-1:0] out_col_ff, out_col_in;
   logic [COORD_W-1:0] out_row_ff, out_row_in;
   logic               out_last_ff, out_last_in;

   logic               hit;
   logic [COORD_W-1:0] dest_col, dest_row;
   logic               frame_last;
   logic               out_free, consume, req_xfer, load_out;

   // a held pixel is scanned before any register write restarts the frame
   assign csr_ready = !in_valid_ff;
   assign csr_write = csr_valid && csr_ready;

   nnds_ratio_unit #(.FRAC_BITS(FRAC_BITS)) u_ratio (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .geometry  (geometry),
      .col_ratio (col_ratio),
      .row_ratio (row_ratio),
      .busy      (ratio_busy)
   );

   nnds_scan #(.FRAC_BITS(FRAC_BITS)) u_scan (
      .clock      (clock),
      .reset      (reset),
      .restart    (csr_write),
      .step       (in_valid_ff && consume),
      .geometry   (geometry),
      .col_ratio  (col_ratio),
      .row_ratio  (row_ratio),
      .hit        (hit),
      .dest_col   (dest_col),
      .dest_row   (dest_row),
      .frame_last (frame_last)
   );

   // a held pixel leaves the input register when it is skipped or the result
   // register can take it; a pending register write goes first
   assign out_free   = !out_valid_ff || rsp_tready;
   assign consume    = !hit || out_free;
   assign req_tready = !ratio_busy && !csr_valid && (!in_valid_ff || consume);
   assign req_xfer   = req_tvalid && req_tready;
   assign load_out   = in_valid_ff && hit && out_free;

   always_comb begin
      in_valid_in = in_valid_ff;
      pixel_in    = pixel_ff;
      if (csr_write) begin
         in_valid_in = 1'b0;
      end else if (req_xfer) begin
         in_valid_in = 1'b1;
         pixel_in    = req_tdata;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_pixel_in = out_pixel_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      out_last_in  = out_last_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
         out_pixel_in = pixel_ff;
         out_col_in   = dest_col;
         out_row_in   = dest_row;
         out_last_in  = frame_last;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      pixel_ff     <= pixel_in;
      out_pixel_ff <= out_pixel_in;
      out_col_ff   <= out_col_in;
      out_row_ff   <= out_row_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({out_row_ff, out_col_ff, out_pixel_ff});
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

[src/nnds_divider.sv]
`default_nettype none

// restoring divider, one quotient bit per cycle
module nnds_divider
   #(
      parameter int NUM_W = 29,
      parameter int DEN_W = 13
   )
   (
      input  wire logic             clock,
      input  wire logic             reset,
      input  wire logic             start,
      input  wire logic [NUM_W-1:0] numerator,
      input  wire logic [DEN_W-1:0] denominator,
      output logic                  busy,
      output logic [NUM_W-1:0]      quotient
   );

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [NUM_W-1:0] quot_ff, quot_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   rem_shift;
   logic             fits;

   assign rem_shift = {rem_ff, quot_ff[NUM_W-1]};
   assign fits      = rem_shift >= {1'b0, den_ff};

   always_comb begin
      count_in = count_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      if (start) begin
         count_in = CNT_W'(NUM_W);
         quot_in  = numerator;
         rem_in   = '0;
         den_in   = denominator;
      end else if (count_ff != '0) begin
         count_in = count_ff - CNT_W'(1);
         quot_in  = {quot_ff[NUM_W-2:0], fits};
         rem_in   = fits ? DEN_W'(rem_shift - {1'b0, den_ff}) : rem_shift[DEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign busy     = count_ff != '0;
   assign quotient = quot_ff;

endmodule

`default_nettype wire

[src/nnds_ratio_unit.sv]
`default_nettype none

// size registers and the two step ratios derived from them
module nnds_ratio_unit
   import nnds_pkg::*;
   #(
      parameter int FRAC_BITS = 16
   )
   (
      input  wire logic                         clock,
      input  wire logic                         reset,
      input  wire logic                         csr_valid,
      input  wire logic [CSR_IDX_W-1:0]         csr_index,
      input  wire logic [DIM_W-1:0]             csr_data,
      output geometry_type                      geometry,
      output logic [DIM_W+FRAC_BITS-1:0]        col_ratio,
      output logic [DIM_W+FRAC_BITS-1:0]        row_ratio,
      output logic                              busy
   );

   localparam int POS_W = DIM_W + FRAC_BITS;

   logic [DIM_W-1:0] src_w_ff, src_w_in;
   logic [DIM_W-1:0] src_h_ff, src_h_in;
   logic [DIM_W-1:0] tgt_w_ff, tgt_w_in;
   logic [DIM_W-1:0] tgt_h_ff, tgt_h_in;
   logic             start_ff;
   logic             col_busy, row_busy;
   logic [DIM_W-1:0] clamped;

   assign clamped = clamp_dim(csr_data);

   always_comb begin
      src_w_in = src_w_ff;
      src_h_in = src_h_ff;
      tgt_w_in = tgt_w_ff;
      tgt_h_in = tgt_h_ff;
      if (csr_valid) begin
         unique case (csr_reg_type'(csr_index))
            REG_SOURCE_WIDTH:  src_w_in = clamped;
            REG_SOURCE_HEIGHT: src_h_in = clamped;
            REG_TARGET_WIDTH:  tgt_w_in = clamped;
            REG_TARGET_HEIGHT: tgt_h_in = clamped;
            default:           src_w_in = src_w_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= RST_SOURCE_WIDTH;
         src_h_ff <= RST_SOURCE_HEIGHT;
         tgt_w_ff <= RST_TARGET_WIDTH;
         tgt_h_ff <= RST_TARGET_HEIGHT;
         start_ff <= 1'b1;
      end else begin
         src_w_ff <= src_w_in;
         src_h_ff <= src_h_in;
         tgt_w_ff <= tgt_w_in;
         tgt_h_ff <= tgt_h_in;
         start_ff <= csr_valid;
      end
   end

   // downscaling only: a target above the source is held at the source size
   assign geometry.src_w = src_w_ff;
   assign geometry.src_h = src_h_ff;
   assign geometry.tgt_w = (tgt_w_ff < src_w_ff) ? tgt_w_ff : src_w_ff;
   assign geometry.tgt_h = (tgt_h_ff < src_h_ff) ? tgt_h_ff : src_h_ff;

   nnds_divider #(.NUM_W(POS_W), .DEN_W(DIM_W)) u_col_div (
      .clock       (clock),
      .reset       (reset),
      .start       (start_ff),
      .numerator   ({geometry.src_w, {FRAC_BITS{1'b0}}}),
      .denominator (geometry.tgt_w),
      .busy        (col_busy),
      .quotient    (col_ratio)
   );

   nnds_divider #(.NUM_W(POS_W), .DEN_W(DIM_W)) u_row_div (
      .clock       (clock),
      .reset       (reset),
      .start       (start_ff),
      .numerator   ({geometry.src_h, {FRAC_BITS{1'b0}}}),
      .denominator (geometry.tgt_h),
      .busy        (row_busy),
      .quotient    (row_ratio)
   );

   assign busy = start_ff || col_busy || row_busy;

endmodule

`default_nettype wire

[src/nnds_scan.sv]
`default_nettype none

// source and target position tracking, hit decision per pixel
module nnds_scan
   import nnds_pkg::*;
   #(
      parameter int FRAC_BITS = 16
   )
   (
      input  wire logic                  clock,
      input  wire logic                  reset,
      input  wire logic                  restart,
      input  wire logic                  step,
      input  wire geometry_type          geometry,
      input  wire logic [DIM_W+FRAC_BITS-1:0] col_ratio,
      input  wire logic [DIM_W+FRAC_BITS-1:0] row_ratio,
      output logic                       hit,
      output logic [COORD_W-1:0]         dest_col,
      output logic [COORD_W-1:0]         dest_row,
      output logic                       frame_last
   );

   localparam int POS_W = DIM_W + FRAC_BITS;

   logic [COORD_W-1:0] src_col_ff, src_col_in;
   logic [COORD_W-1:0] src_row_ff, src_row_in;
   logic [DIM_W-1:0]   dst_col_ff, dst_col_in;
   logic [DIM_W-1:0]   dst_row_ff, dst_row_in;
   logic [POS_W-1:0]   want_col_ff, want_col_in;
   logic [POS_W-1:0]   want_row_ff, want_row_in;
   logic               row_hit, col_hit, col_end, row_end;

   assign row_hit = (dst_row_ff < geometry.tgt_h)
                    && ({1'b0, src_row_ff} == want_row_ff[POS_W-1:FRAC_BITS]);
   assign col_hit = (dst_col_ff < geometry.tgt_w)
                    && ({1'b0, src_col_ff} == want_col_ff[POS_W-1:FRAC_BITS]);
   assign hit     = row_hit && col_hit;
   assign col_end = ({1'b0, src_col_ff} + DIM_W'(1)) >= geometry.src_w;
   assign row_end = ({1'b0, src_row_ff} + DIM_W'(1)) >= geometry.src_h;

   always_comb begin
      src_col_in  = src_col_ff;
      src_row_in  = src_row_ff;
      dst_col_in  = dst_col_ff;
      dst_row_in  = dst_row_ff;
      want_col_in = want_col_ff;
      want_row_in = want_row_ff;
      if (restart) begin
         src_col_in  = '0;
         src_row_in  = '0;
         dst_col_in  = '0;
         dst_row_in  = '0;
         want_col_in = '0;
         want_row_in = '0;
      end else if (step) begin
         if (hit) begin
            dst_col_in  = dst_col_ff + DIM_W'(1);
            want_col_in = want_col_ff + col_ratio;
         end
         if (col_end) begin
            src_col_in  = '0;
            dst_col_in  = '0;
            want_col_in = '0;
            if (row_hit) begin
               dst_row_in  = dst_row_ff + DIM_W'(1);
               want_row_in = want_row_ff + row_ratio;
            end
            if (row_end) begin
               src_row_in  = '0;
               dst_row_in  = '0;
               want_row_in = '0;
            end else begin
               src_row_in = src_row_ff + COORD_W'(1);
            end
         end else begin
            src_col_in = src_col_ff + COORD_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_col_ff  <= '0;
         src_row_ff  <= '0;
         dst_col_ff  <= '0;
         dst_row_ff  <= '0;
         want_col_ff <= '0;
         want_row_ff <= '0;
      end else begin
         src_col_ff  <= src_col_in;
         src_row_ff  <= src_row_in;
         dst_col_ff  <= dst_col_in;
         dst_row_ff  <= dst_row_in;
         want_col_ff <= want_col_in;
         want_row_ff <= want_row_in;
      end
   end

   assign dest_col   = dst_col_ff[COORD_W-1:0];
   assign dest_row   = dst_row_ff[COORD_W-1:0];
   assign frame_last = (dst_col_ff == geometry.tgt_w - DIM_W'(1))
                       && (dst_row_ff == geometry.tgt_h - DIM_W'(1));

endmodule

`default_nettype wire

[src/nnds_checker.sv]
`default_nettype none

module nnds_checker
   import nnds_pkg::*;
   #(
      parameter int BYTES_PER_PIXEL = 4
   )
   (
      input wire logic                          clock,
      input wire logic                          reset,
      input wire logic                          req_tvalid,
      input wire logic                          req_tready,
      input wire logic                          rsp_tvalid,
      input wire logic                          rsp_tready,
      input wire logic [((8*BYTES_PER_PIXEL+2*COORD_W+7)/8)*8-1:0] rsp_tdata,
      input wire logic                          rsp_tlast,
      input wire logic                          csr_valid,
      input wire logic                          csr_ready
   );

   // a stalled result keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   // a register write starts the ratio calculation, so no pixel is taken next cycle
   a_csr_blocks: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> !req_tready)
      else $error("pixel accepted during ratio calculation");

   // a fresh result comes from a pixel that went through the input register straight into the result register
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("response without a matching request");

   // a register write is only taken with the input register empty, so no held pixel can follow it out
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> !$rose(rsp_tvalid))
      else $error("response appeared right after a register write");

endmodule

bind nearest_neighbor_downscaler_core nnds_checker #(
   .BYTES_PER_PIXEL (BYTES_PER_PIXEL)
) u_nnds_checker (.*);

`default_nettype wire

[tb/nearest_neighbor_downscaler_core_tb.sv]
`timescale 1ns / 1ps

module nearest_neighbor_downscaler_core_tb;
   import nnds_pkg::*;

   localparam int FRAC          = 16;
   localparam int PIX_W         = 32;
   localparam int RSP_W         = 56;
   localparam int SETTLE_CYCLES = 4;
   localparam int RANDOM_PIXELS = 1400;

   // one pixel of the scaled image as it should leave the block
   typedef struct packed {
      logic [PIX_W-1:0]   pixel;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic               last;
   } scaled_px;

   // one row of the directed plan: a size register write or a source pixel,
   // the latter optionally with its outcome written out by hand
   typedef struct packed {
      logic               is_write;
      csr_reg_type        which;
      logic [DIM_W-1:0]   value;
      logic [PIX_W-1:0]   pixel;
      logic               known;
      logic               hit;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic               last;
   } plan_step;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [PIX_W-1:0]     req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 rsp_tlast;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DIM_W-1:0]     csr_data = '0;

   // size registers as the block should see them, already limited to 1..MAX_DIM
   int unsigned cfg_src_w, cfg_src_h, cfg_tgt_w, cfg_tgt_h;
   // scan position in the source frame and the next target pixel still owed
   int unsigned in_col, in_row, out_col, out_row;
   // 16.16 positions of the next wanted source column and row, and their steps
   longint unsigned col_aim, row_aim, col_step, row_step;

   scaled_px owed[$];
   int       mismatches = 0;
   int       pixels_fed = 0;
   bit       no_idle = 1'b0;
   int       stall_left = 0;

   nearest_neighbor_downscaler_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("** nearest_neighbor_downscaler_core: FAILED **");
      $finish;
   end

   // ---------------------------------------------------------------- scaler prediction

   // zero reads as one, anything past the largest frame edge as that edge
   function automatic int unsigned limit_size(input logic [DIM_W-1:0] v);
      if (v == '0) begin
         return 1;
      end
      if (v > DIM_W'(MAX_DIM)) begin
         return MAX_DIM;
      end
      return 32'(v);
   endfunction

   // downscaling only: a target wider or taller than the source is cut back
   function automatic int unsigned shrunk(input int unsigned tgt, input int unsigned src);
      return (tgt < src) ? tgt : src;
   endfunction

   // fresh ratios and a fresh frame, as after reset or any register write
   function automatic void restart_scaler();
      col_step = (64'(cfg_src_w) << FRAC) / shrunk(cfg_tgt_w, cfg_src_w);
      row_step = (64'(cfg_src_h) << FRAC) / shrunk(cfg_tgt_h, cfg_src_h);
      in_col   = 0;
      in_row   = 0;
      out_col  = 0;
      out_row  = 0;
      col_aim  = 0;
      row_aim  = 0;
   endfunction

   function automatic void apply_size(input csr_reg_type r, input logic [DIM_W-1:0] v);
      case (r)
         REG_SOURCE_WIDTH: begin
            cfg_src_w = limit_size(v);
         end
         REG_SOURCE_HEIGHT: begin
            cfg_src_h = limit_size(v);
         end
         REG_TARGET_WIDTH: begin
            cfg_tgt_w = limit_size(v);
         end
         default: begin
            cfg_tgt_h = limit_size(v);
         end
      endcase
      restart_scaler();
   endfunction

   // one source pixel in; says whether it is kept and where it lands
   task automatic scale_pixel(input logic [PIX_W-1:0] pix, output bit hit,
                              output scaled_px px);
      int unsigned eff_w, eff_h;
      bit          on_row, on_col;
      eff_w  = shrunk(cfg_tgt_w, cfg_src_w);
      eff_h  = shrunk(cfg_tgt_h, cfg_src_h);
      on_row = (out_row < eff_h) && (64'(in_row) == (row_aim >> FRAC));
      on_col = (out_col < eff_w) && (64'(in_col) == (col_aim >> FRAC));
      hit    = on_row && on_col;
      px.pixel = pix;
      px.col   = out_col[COORD_W-1:0];
      px.row   = out_row[COORD_W-1:0];
      px.last  = (out_col == eff_w - 1) && (out_row == eff_h - 1);
      if (hit) begin
         out_col++;
         col_aim += col_step;
      end
      // end of a source row: column tracking starts over, the row moves on
      // only when this row was one of the wanted ones
      if (in_col + 1 >= cfg_src_w) begin
         in_col  = 0;
         out_col = 0;
         col_aim = 0;
         if (on_row) begin
            out_row++;
            row_aim += row_step;
         end
         if (in_row + 1 >= cfg_src_h) begin
            in_row  = 0;
            out_row = 0;
            row_aim = 0;
         end else begin
            in_row++;
         end
      end else begin
         in_col++;
      end
   endtask

   // ---------------------------------------------------------------- driving

   function automatic int idle_draw();
      return no_idle ? 0 : $urandom_range(0, 10);
   endfunction

   // sink side: after every transfer hold tready low for a random stretch, which may be none
   always @(posedge clock) begin : response_stalls
      int pause;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         pause = idle_draw();
         rsp_tready <= (pause == 0);
         stall_left <= pause;
      end else if (stall_left > 1) begin
         stall_left <= stall_left - 1;
      end else begin
         stall_left <= 0;
         rsp_tready <= 1'b1;
      end
   end

   // one size register write; valid stays up into the next write when no gap is drawn
   task automatic write_size(input csr_reg_type r, input logic [DIM_W-1:0] v);
      int gap;
      gap = idle_draw();
      if (gap > 0) begin
         csr_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      csr_valid <= 1'b1;
      csr_index <= r;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      apply_size(r, v);
   endtask

   // one source pixel; the expectation is queued at the transfer edge.
   // a hand-written outcome, where given, replaces the predicted one
   task automatic send_pixel(input logic [PIX_W-1:0] pix, input bit known,
                             input bit known_hit, input scaled_px known_px);
      int       gap;
      bit       hit;
      scaled_px px;
      gap = idle_draw();
      csr_valid <= 1'b0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      do @(posedge clock); while (!req_tready);
      scale_pixel(pix, hit, px);
      if (known) begin
         hit = known_hit;
         px  = known_px;
      end
      if (hit) begin
         owed.push_back(px);
      end
      pixels_fed++;
   endtask

   // wait for the block to go idle: everything owed delivered, plus a settling
   // margin while a skipped pixel may still sit in the input register
   task automatic settle();
      req_tvalid <= 1'b0;
      while (owed.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- checking

   always @(posedge clock) begin : check_responses
      scaled_px want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (owed.size() == 0) begin
            $display("%0t: unexpected pixel, expected none, got %h col %0d row %0d",
                     $time, rsp_tdata[31:0], rsp_tdata[43:32], rsp_tdata[55:44]);
            mismatches++;
         end else begin
            want = owed.pop_front();
            if (rsp_tdata[31:0] !== want.pixel) begin
               $display("%0t: pixel expected %h, got %h", $time, want.pixel,
                        rsp_tdata[31:0]);
               mismatches++;
            end
            if (rsp_tdata[43:32] !== want.col) begin
               $display("%0t: dest col expected %0d, got %0d", $time, want.col,
                        rsp_tdata[43:32]);
               mismatches++;
            end
            if (rsp_tdata[55:44] !== want.row) begin
               $display("%0t: dest row expected %0d, got %0d", $time, want.row,
                        rsp_tdata[55:44]);
               mismatches++;
            end
            if (rsp_tlast !== want.last) begin
               $display("%0t: frame end expected %0b, got %0b", $time, want.last,
                        rsp_tlast);
               mismatches++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic plan_step size_row(input csr_reg_type r, input logic [DIM_W-1:0] v);
      plan_step s;
      s          = '0;
      s.is_write = 1'b1;
      s.which    = r;
      s.value    = v;
      return s;
   endfunction

   function automatic plan_step pix_row(input logic [PIX_W-1:0] p);
      plan_step s;
      s       = '0;
      s.which = REG_SOURCE_WIDTH;
      s.pixel = p;
      return s;
   endfunction

   function automatic plan_step pix_known(input logic [PIX_W-1:0] p, input bit hit,
                                          input int col, input int row, input bit last);
      plan_step s;
      s       = pix_row(p);
      s.known = 1'b1;
      s.hit   = hit;
      s.col   = col[COORD_W-1:0];
      s.row   = row[COORD_W-1:0];
      s.last  = last;
      return s;
   endfunction

   initial begin : stimulus
      plan_step         plan[$];
      plan_step         s;
      scaled_px         hand;
      bit               in_writes;
      int               shape, frame, n, k;
      logic [DIM_W-1:0] sizes [4];
      csr_reg_type      r;

      cfg_src_w = limit_size(RST_SOURCE_WIDTH);
      cfg_src_h = limit_size(RST_SOURCE_HEIGHT);
      cfg_tgt_w = limit_size(RST_TARGET_WIDTH);
      cfg_tgt_h = limit_size(RST_TARGET_HEIGHT);
      restart_scaler();

      // default frame 1920x1080 to 192x108: only every tenth column is kept
      plan.push_back(pix_known(32'hFFFF_FFFF, 1, 0, 0, 0));
      plan.push_back(pix_known(32'h0000_0000, 0, 0, 0, 0));
      // zero sizes read as one, oversize targets as the maximum: every pixel
      // is a whole 1x1 frame of its own
      plan.push_back(size_row(REG_SOURCE_WIDTH, 13'd0));
      plan.push_back(size_row(REG_SOURCE_HEIGHT, 13'd0));
      plan.push_back(size_row(REG_TARGET_WIDTH, 13'h1FFF));
      plan.push_back(size_row(REG_TARGET_HEIGHT, 13'd4096));
      plan.push_back(pix_known(32'hA5A5_A5A5, 1, 0, 0, 1));
      plan.push_back(pix_known(32'h5A5A_5A5A, 1, 0, 0, 1));
      // widest row at full size: every pixel passes straight through
      plan.push_back(size_row(REG_SOURCE_WIDTH, 13'd4096));
      plan.push_back(size_row(REG_TARGET_WIDTH, 13'd4096));
      plan.push_back(pix_known(32'h8000_0001, 1, 0, 0, 0));
      plan.push_back(pix_known(32'h7FFF_FFFE, 1, 1, 0, 0));
      // tallest single column at full size
      plan.push_back(size_row(REG_SOURCE_WIDTH, 13'd1));
      plan.push_back(size_row(REG_SOURCE_HEIGHT, 13'd4096));
      plan.push_back(pix_known(32'hF0F0_F0F0, 1, 0, 0, 0));
      plan.push_back(pix_known(32'h0000_FFFF, 1, 0, 1, 0));
      // 5x3 to 3 wide with a ratio that is not whole, target height cut back
      // to the source, one full frame and the first pixel of the next
      plan.push_back(size_row(REG_SOURCE_WIDTH, 13'd5));
      plan.push_back(size_row(REG_SOURCE_HEIGHT, 13'd3));
      plan.push_back(size_row(REG_TARGET_WIDTH, 13'd3));
      plan.push_back(size_row(REG_TARGET_HEIGHT, 13'd7));
      for (int i = 0; i < 16; i++) begin
         plan.push_back(pix_row(32'h1111_1111 * (i % 15) + 32'h0102_0304 * i));
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      in_writes = 1'b0;
      foreach (plan[i]) begin
         s = plan[i];
         if (s.is_write) begin
            if (!in_writes) begin
               settle();
            end
            write_size(s.which, s.value);
         end else begin
            hand.pixel = s.pixel;
            hand.col   = s.col;
            hand.row   = s.row;
            hand.last  = s.last;
            send_pixel(s.pixel, s.known, s.hit, hand);
         end
         in_writes = s.is_write;
      end

      // random frame shapes, mostly small so whole frames and wraps happen
      // often, now and then one very long edge with a partial frame
      pixels_fed = 0;
      hand       = '0;
      while (pixels_fed < RANDOM_PIXELS) begin
         settle();
         no_idle = ($urandom_range(0, 3) == 0);
         shape   = $urandom_range(0, 9);
         case (shape)
            0: begin
               sizes[0] = DIM_W'($urandom_range(1, 4096));
               sizes[1] = DIM_W'($urandom_range(1, 3));
            end
            1: begin
               sizes[0] = DIM_W'($urandom_range(1, 3));
               sizes[1] = DIM_W'($urandom_range(1, 4096));
            end
            default: begin
               sizes[0] = DIM_W'($urandom_range(1, 12));
               sizes[1] = DIM_W'($urandom_range(1, 10));
            end
         endcase
         // targets may overshoot the source so the cut-back is exercised
         sizes[2] = DIM_W'($urandom_range(1, 32'(sizes[0]) + 3));
         sizes[3] = DIM_W'($urandom_range(1, 32'(sizes[1]) + 3));
         // odd values outside the legal range on any register now and then
         for (int i = 0; i < 4; i++) begin
            if ($urandom_range(0, 15) == 0) begin
               sizes[i] = $urandom_range(0, 1) ? 13'd0 : DIM_W'($urandom_range(4097, 8191));
            end
         end
         if ($urandom_range(0, 4) != 0) begin
            k = $urandom_range(0, 3);
            for (int i = 0; i < 4; i++) begin
               r = csr_reg_type'((k + i) % 4);
               write_size(r, sizes[r]);
            end
         end else begin
            r = csr_reg_type'($urandom_range(0, 3));
            write_size(r, sizes[r]);
         end
         frame = int'(cfg_src_w * cfg_src_h);
         if (frame <= 120) begin
            n = frame * $urandom_range(1, 3) + $urandom_range(0, frame);
         end else begin
            n = $urandom_range(20, 150);
         end
         for (int i = 0; i < n; i++) begin
            send_pixel($urandom, 1'b0, 1'b0, hand);
         end
      end

      settle();
      if (mismatches == 0 && owed.size() == 0) begin
         $display("** nearest_neighbor_downscaler_core: PASSED **");
      end else begin
         $display("** nearest_neighbor_downscaler_core: FAILED **");
      end
      $finish;
   end

endmodule

[filelist.f]
src/nnds_pkg.sv
src/nnds_divider.sv
src/nnds_ratio_unit.sv
src/nnds_scan.sv
src/nearest_neighbor_downscaler_core.sv
src/nnds_checker.sv
tb/nearest_neighbor_downscaler_core_tb.sv
